// ===== hw/rtl/spe_pkg.sv =====
// ============================================================================
// spe_pkg
// Shared types and constants for the shortest path engine.
// ============================================================================
package spe_pkg;

  localparam logic [1:0] STATUS_PATH    = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_NO_PATH = 2'd2;
  localparam logic [1:0] STATUS_WRITTEN = 2'd3;

  localparam logic [1:0] OWNER_RIVAL = 2'd2;
  localparam logic [11:0] DIST_MAX = 12'd4095;

  localparam logic CFG_NODE_COUNT = 1'b0;
  localparam logic CFG_EDGE_COUNT = 1'b1;

  typedef struct packed {
    logic clear;      // start a clear sweep of the node scratch
    logic scan;       // start a minimum scan
    logic relax;      // start an edge sweep for the settled node
    logic walk;       // start the predecessor walk
    logic emit;       // start streaming the path
  } spe_cmd_t;

  typedef struct packed {
    logic busy;
    logic found;      // last scan found a node
    logic is_end;     // the node found is the end node
    logic end_reached;
    logic emit_done;
  } spe_stat_t;

endpackage

// ===== hw/rtl/spe_ram.sv =====
// ============================================================================
// spe_ram
// Generic single-port-write, one-read RAM with registered read data.
// ============================================================================
module spe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/spe_datapath.sv =====
// ============================================================================
// spe_datapath
// Node scratch, edge sweep, minimum scan, predecessor walk and path output.
// ============================================================================
module spe_datapath #(
  parameter int MAX_NODES = 32,
  parameter int MAX_EDGES = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  spe_pkg::spe_cmd_t  cmd,
  output spe_pkg::spe_stat_t stat,
  input  logic               edge_we,
  input  logic [6:0]         edge_index,
  input  logic [4:0]         edge_from,
  input  logic [4:0]         edge_to,
  input  logic [5:0]         edge_length,
  input  logic [1:0]         edge_owner,
  input  logic [6:0]         n_eff,
  input  logic [10:0]        m_eff,
  input  logic [5:0]         start_node,
  input  logic [5:0]         end_node,
  output logic               path_valid,
  input  logic               path_ready,
  output logic [4:0]         path_node,
  output logic [11:0]        path_distance,
  output logic               path_last
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

  typedef enum logic [2:0] {
    D_IDLE, D_CLEAR, D_SCAN, D_RELAX, D_WALK, D_EMIT
  } dstate_t;

  dstate_t dstate;

  // node scratch: reached and visited as flags, distance and predecessor in RAM
  logic [MAX_NODES-1:0] reached;
  logic [MAX_NODES-1:0] visited;

  logic          dist_we;
  logic [NW-1:0] dist_waddr;
  logic [11:0]   dist_wdata;
  logic [NW-1:0] dist_raddr;
  logic [11:0]   dist_rdata;
  logic          pred_we;
  logic [NW-1:0] pred_raddr;
  logic [NW-1:0] pred_rdata;
  logic          path_we;
  logic [NW-1:0] path_waddr;
  logic [NW-1:0] path_raddr;
  logic [NW-1:0] path_rdata;
  logic [EW-1:0] edge_raddr;
  logic [17:0]   edge_rdata;

  logic [NW:0]   idx;        // node counter
  logic [10:0]   eidx;       // edge counter
  logic          phase;      // alternates RAM read issue and use of the read data
  logic [NW-1:0] cur_u;
  logic [11:0]   cur_d;
  logic          best_ok;
  logic [NW-1:0] best_u;
  logic [11:0]   best_d;
  logic [NW-1:0] cand;
  logic          cand_ok;
  logic [NW-1:0] walk_node;
  logic [NW:0]   plen;
  logic [NW:0]   opos;
  logic          found;
  logic          is_end;
  logic          obuf_ok;

  spe_ram #(.WIDTH(18), .DEPTH(MAX_EDGES)) u_edge (
    .clk, .we(edge_we), .waddr(edge_index[EW-1:0]),
    .wdata({edge_owner, edge_length, edge_to, edge_from}),
    .raddr(edge_raddr), .rdata(edge_rdata));
  spe_ram #(.WIDTH(12), .DEPTH(MAX_NODES)) u_dist (
    .clk, .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
    .raddr(dist_raddr), .rdata(dist_rdata));
  spe_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_pred (
    .clk, .we(pred_we), .waddr(dist_waddr), .wdata(cur_u),
    .raddr(pred_raddr), .rdata(pred_rdata));
  spe_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_path (
    .clk, .we(path_we), .waddr(path_waddr), .wdata(walk_node),
    .raddr(path_raddr), .rdata(path_rdata));

  // edge decode (edge data registered at the RAM)
  logic [4:0]  ea, eb;
  logic [5:0]  ew;
  logic [1:0]  eo;
  logic [6:0]  ea_x, eb_x;
  logic        e_hit;
  logic [4:0]  e_oth;
  logic [12:0] nd_sum;
  logic [11:0] nd;
  logic [NW-1:0] u5;

  assign {eo, ew, eb, ea} = edge_rdata;
  assign ea_x = {2'b00, ea};
  assign eb_x = {2'b00, eb};
  assign u5 = cur_u;
  assign e_hit = (eo != spe_pkg::OWNER_RIVAL) && (ea_x < n_eff) && (eb_x < n_eff)
                 && ((ea[NW-1:0] == u5) || (eb[NW-1:0] == u5));
  assign e_oth = (ea[NW-1:0] == u5) ? eb : ea;
  assign nd_sum = {1'b0, cur_d} + {7'd0, ew};
  assign nd = nd_sum[12] ? spe_pkg::DIST_MAX : nd_sum[11:0];

  // relax pipeline: edge read, then dist read of other end, then update
  logic          r1_ok, r2_ok, r3_ok;
  logic [NW-1:0] r1_v, r2_v, r3_v;
  logic [11:0]   r1_nd, r2_nd, r3_nd;
  logic          r2_better;
  logic          fwd_hit;
  logic          bck_hit;

  assign fwd_hit = r2_ok && r2_better && (r2_v == r1_v);
  assign bck_hit = r3_ok && (r3_v == r1_v);

  always_comb begin
    dist_we    = 1'b0;
    pred_we    = 1'b0;
    dist_waddr = r2_v;
    dist_wdata = r2_nd;
    dist_raddr = cand;
    pred_raddr = walk_node;
    edge_raddr = eidx[EW-1:0];
    if (dstate == D_RELAX) begin
      dist_raddr = e_oth[NW-1:0];
      dist_we    = r2_ok && r2_better;
      pred_we    = r2_ok && r2_better;
    end else if (dstate == D_CLEAR) begin
      dist_we    = 1'b1;
      dist_waddr = idx[NW-1:0];
      dist_wdata = '0;
    end
  end

  assign cand = idx[NW-1:0];
  assign cand_ok = (idx < n_eff[NW:0]) && reached[cand] && !visited[cand];
  assign path_we = (dstate == D_WALK) && phase;
  assign path_waddr = plen[NW-1:0];
  assign path_raddr = NW'(plen - opos - 1'b1);

  assign stat.busy = (dstate != D_IDLE) || cmd.clear || cmd.scan || cmd.relax
                     || cmd.walk || cmd.emit;
  assign stat.found = found;
  assign stat.is_end = is_end;
  assign stat.end_reached = reached[end_node[NW-1:0]];
  assign stat.emit_done = (dstate == D_IDLE) && !path_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate     <= D_IDLE;
      reached    <= '0;
      visited    <= '0;
      found      <= 1'b0;
      is_end     <= 1'b0;
      path_valid <= 1'b0;
      obuf_ok    <= 1'b0;
      phase      <= 1'b0;
      r1_ok      <= 1'b0;
      r2_ok      <= 1'b0;
      r3_ok      <= 1'b0;
    end else begin
      case (dstate)
        D_IDLE: begin
          phase <= 1'b0;
          idx   <= '0;
          eidx  <= '0;
          if (cmd.clear) begin
            dstate <= D_CLEAR;
          end else if (cmd.scan) begin
            dstate  <= D_SCAN;
            best_ok <= 1'b0;
          end else if (cmd.relax) begin
            dstate <= D_RELAX;
            r1_ok  <= 1'b0;
            r2_ok  <= 1'b0;
            r3_ok  <= 1'b0;
          end else if (cmd.walk) begin
            dstate        <= D_WALK;
            walk_node     <= end_node[NW-1:0];
            plen          <= '0;
            path_distance <= (start_node == end_node) ? 12'd0 : cur_d;
          end else if (cmd.emit) begin
            dstate  <= D_EMIT;
            opos    <= '0;
            obuf_ok <= 1'b0;
          end
        end
        D_CLEAR: begin
          reached[idx[NW-1:0]] <= (idx[NW-1:0] == start_node[NW-1:0]);
          visited[idx[NW-1:0]] <= 1'b0;
          idx <= idx + 1'b1;
          if (idx == (NW+1)'(MAX_NODES - 1)) begin
            dstate <= D_IDLE;
          end
        end
        D_SCAN: begin
          // phase 0 issues read of cand, phase 1 compares
          phase <= !phase;
          if (phase) begin
            if (cand_ok && (!best_ok || dist_rdata < best_d)) begin
              best_ok <= 1'b1;
              best_u  <= cand;
              best_d  <= dist_rdata;
            end
            idx <= idx + 1'b1;
            if (idx + 1'b1 >= n_eff[NW:0]) begin
              dstate <= D_IDLE;
              found  <= best_ok || cand_ok;
              if (cand_ok && (!best_ok || dist_rdata < best_d)) begin
                cur_u  <= cand;
                cur_d  <= dist_rdata;
                is_end <= (cand == end_node[NW-1:0]);
                visited[cand] <= 1'b1;
              end else begin
                cur_u  <= best_u;
                cur_d  <= best_d;
                is_end <= (best_u == end_node[NW-1:0]);
                if (best_ok) begin
                  visited[best_u] <= 1'b1;
                end
              end
            end
          end
        end
        D_RELAX: begin
          // stage 0: edge address; stage 1: decode, read dist; stage 2: update
          r1_ok <= (eidx != '0) && (eidx <= m_eff) && e_hit;
          r1_v  <= e_oth[NW-1:0];
          r1_nd <= nd;
          r2_ok <= r1_ok;
          r2_v  <= r1_v;
          r2_nd <= r1_nd;
          r3_ok <= r2_ok && r2_better;
          r3_v  <= r2_v;
          r3_nd <= r2_nd;
          if (fwd_hit) begin
            r2_better <= (r1_nd < r2_nd);
          end else if (bck_hit) begin
            r2_better <= (r1_nd < r3_nd);
          end else begin
            r2_better <= !reached[r1_v] || (r1_nd < dist_rdata);
          end
          if (r2_ok && r2_better) begin
            reached[r2_v] <= 1'b1;
          end
          eidx <= eidx + 1'b1;
          if (eidx == m_eff + 11'd2) begin
            dstate <= D_IDLE;
          end
        end
        D_WALK: begin
          // phase 0 reads predecessor, phase 1 stores node and steps
          phase <= !phase;
          if (phase) begin
            plen <= plen + 1'b1;
            if ((walk_node == start_node[NW-1:0])
                || (plen == (NW+1)'(MAX_NODES - 1))) begin
              dstate <= D_IDLE;
            end
            walk_node <= pred_rdata;
          end
        end
        D_EMIT: begin
          if (!obuf_ok) begin
            obuf_ok <= 1'b1;
            if (path_valid && path_ready) begin
              path_valid <= 1'b0;
            end
          end else if (!path_valid || path_ready) begin
            path_valid    <= 1'b1;
            path_node     <= 5'(path_rdata);
            path_last     <= (opos + 1'b1 == plen);
            opos          <= opos + 1'b1;
            obuf_ok       <= 1'b0;
            if (opos + 1'b1 == plen) begin
              dstate <= D_IDLE;
            end
          end
        end
        default: dstate <= D_IDLE;
      endcase
      if (dstate == D_IDLE && path_valid && path_ready) begin
        path_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/spe_ctrl.sv =====
// ============================================================================
// spe_ctrl
// Sequencer: accepts words, runs the search loop, issues single results.
// ============================================================================
module spe_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic [5:0]         start_node,
  input  logic [5:0]         end_node,
  input  logic [6:0]         n_eff,
  output logic               edge_we,
  output logic               q_load,
  output spe_pkg::spe_cmd_t  cmd,
  input  spe_pkg::spe_stat_t stat,
  output logic               single_valid,
  input  logic               single_ready,
  output logic [1:0]         single_status,
  output logic               path_mode
);

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_SCAN, S_DECIDE, S_RELAX, S_WALK, S_EMIT, S_SINGLE
  } state_t;

  state_t state;
  logic [6:0] count;
  logic       dp_busy;
  logic       same_ends;

  assign dp_busy = stat.busy;
  assign in_ready = (state == S_IDLE) && !single_valid;
  assign edge_we = in_valid && in_ready && !op;
  assign q_load  = in_valid && in_ready && op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cmd          <= '0;
      single_valid <= 1'b0;
      path_mode    <= 1'b0;
      count        <= '0;
      same_ends    <= 1'b0;
    end else begin
      cmd <= '0;
      if (single_valid && single_ready) begin
        single_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          path_mode <= 1'b0;
          if (edge_we) begin
            single_valid  <= 1'b1;
            single_status <= spe_pkg::STATUS_WRITTEN;
          end else if (q_load) begin
            same_ends <= (start_node == end_node);
            if ({1'b0, start_node} >= n_eff || {1'b0, end_node} >= n_eff) begin
              single_valid  <= 1'b1;
              single_status <= spe_pkg::STATUS_INVALID;
            end else begin
              cmd.clear <= 1'b1;
              count     <= '0;
              state     <= S_CLEAR;
            end
          end
        end
        S_CLEAR: begin
          if (!dp_busy) begin
            cmd.scan <= 1'b1;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!dp_busy) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          count <= count + 1'b1;
          if (!stat.found || stat.is_end || count + 1'b1 >= n_eff) begin
            if (same_ends || stat.end_reached) begin
              cmd.walk <= 1'b1;
              state    <= S_WALK;
            end else begin
              single_status <= spe_pkg::STATUS_NO_PATH;
              state         <= S_SINGLE;
            end
          end else begin
            cmd.relax <= 1'b1;
            state     <= S_RELAX;
          end
        end
        S_RELAX: begin
          if (!dp_busy) begin
            cmd.scan <= 1'b1;
            state    <= S_SCAN;
          end
        end
        S_WALK: begin
          if (!dp_busy) begin
            cmd.emit  <= 1'b1;
            path_mode <= 1'b1;
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!dp_busy && stat.emit_done) begin
            state <= S_IDLE;
          end
        end
        S_SINGLE: begin
          if (!single_valid) begin
            single_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/shortest_path_engine.sv =====
// An edge write or a rejected query returns one word, registered, in the cycle after acceptance.
// A query's run time is set by the node scan, which reads then compares each node in
// turn, by the edge sweep of each settled node, and by the path walk and output.
// One word is worked on at a time; the next is taken once all results are out.
// Reset clears control state; the edge table reads undefined until written.
// ============================================================================
// shortest_path_engine
// Dijkstra search over a loaded edge table with a linear minimum scan.
// ============================================================================
module shortest_path_engine #(
  parameter int MAX_NODES = 32,
  parameter int MAX_EDGES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [6:0]  edge_index,
  input  logic [4:0]  edge_from,
  input  logic [4:0]  edge_to,
  input  logic [5:0]  edge_length,
  input  logic [1:0]  edge_owner,
  input  logic [5:0]  start_node,
  input  logic [5:0]  end_node,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [4:0]  node,
  output logic [11:0] distance,
  output logic        last
);

  logic [5:0]  node_count;
  logic [7:0]  edge_count;
  logic [6:0]  n_eff;
  logic [10:0] m_eff;
  logic [5:0]  q_start, q_end;
  logic        edge_we, q_load, edge_we_ok;
  spe_pkg::spe_cmd_t  cmd;
  spe_pkg::spe_stat_t stat;
  logic        single_valid, path_valid, path_mode;
  logic [1:0]  single_status;
  logic [4:0]  path_node;
  logic [11:0] path_distance;
  logic        path_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= 6'd32;
      edge_count <= 8'd0;
    end else if (cfg_we) begin
      if (cfg_index == spe_pkg::CFG_NODE_COUNT) begin
        node_count <= cfg_data[5:0];
      end else begin
        edge_count <= cfg_data;
      end
    end
  end

  assign n_eff = ({1'b0, node_count} > 7'(MAX_NODES)) ? 7'(MAX_NODES) : {1'b0, node_count};
  assign m_eff = ({3'b000, edge_count} > 11'(MAX_EDGES)) ? 11'(MAX_EDGES)
                                                        : {3'b000, edge_count};

  always_ff @(posedge clk) begin
    if (q_load) begin
      q_start <= start_node;
      q_end   <= end_node;
    end
  end

  assign edge_we_ok = edge_we && ({1'b0, edge_index} < 8'(MAX_EDGES));

  spe_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .op, .start_node, .end_node, .n_eff,
    .edge_we, .q_load, .cmd, .stat, .single_valid, .single_ready(out_ready),
    .single_status, .path_mode);

  spe_datapath #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_dp (
    .clk, .rst, .cmd, .stat, .edge_we(edge_we_ok), .edge_index, .edge_from,
    .edge_to, .edge_length, .edge_owner, .n_eff, .m_eff,
    .start_node(q_start), .end_node(q_end), .path_valid,
    .path_ready(out_ready), .path_node, .path_distance, .path_last);

  assign out_valid = path_mode ? path_valid : single_valid;
  assign status    = path_mode ? spe_pkg::STATUS_PATH : single_status;
  assign node      = path_mode ? path_node : 5'd0;
  assign distance  = path_mode ? path_distance : 12'd0;
  assign last      = path_mode ? path_last : 1'b1;

endmodule
